// ===== rtl/scs_pkg.sv =====
// shared constants and types of the sparse coordinate sorter
package scs_pkg;

    localparam int MAX_ENTRIES = 64;
    localparam int ADDR_W      = $clog2(MAX_ENTRIES);
    localparam int CNT_W       = $clog2(MAX_ENTRIES + 1);
    localparam int IDX_W       = 16;
    localparam int VAL_W       = 32;
    localparam int DIM_W       = 17;
    localparam int CFG_IDX_W   = 2;
    localparam int CFG_W       = 17;
    localparam int KEY_W       = 2 * IDX_W;

    localparam logic [CFG_IDX_W-1:0] REG_SORT_BY_COLUMN = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_ROWS       = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_NUM_COLS       = 2'd2;

    localparam logic [DIM_W-1:0] DIM_RESET = 17'h10000;

    typedef struct packed {
        logic [IDX_W-1:0]        row;
        logic [IDX_W-1:0]        col;
        logic signed [VAL_W-1:0] value;
    } entry_t;

    typedef struct packed {
        logic   valid;
        logic   last;
        logic   bad;
        entry_t entry;
    } load_t;

    typedef struct packed {
        logic   last;
        logic   error;
        entry_t entry;
    } result_t;

endpackage

// ===== rtl/scs_if.sv =====
// input and output channel interfaces of the sparse coordinate sorter
interface scs_in_if;
    logic                            valid;
    logic                            ready;
    logic [scs_pkg::IDX_W-1:0]       row_index;
    logic [scs_pkg::IDX_W-1:0]       col_index;
    logic signed [scs_pkg::VAL_W-1:0] entry_value;
    logic                            last_in;

    modport source (output valid, row_index, col_index, entry_value, last_in, input ready);
    modport sink   (input valid, row_index, col_index, entry_value, last_in, output ready);
endinterface

interface scs_out_if;
    logic                            valid;
    logic                            ready;
    logic [scs_pkg::IDX_W-1:0]       out_row;
    logic [scs_pkg::IDX_W-1:0]       out_col;
    logic signed [scs_pkg::VAL_W-1:0] out_value;
    logic                            out_last;
    logic                            out_error;

    modport source (output valid, out_row, out_col, out_value, out_last, out_error, input ready);
    modport sink   (input valid, out_row, out_col, out_value, out_last, out_error, output ready);
endinterface

// ===== rtl/scs_key_cmp.sv =====
// shared order-key comparator: true when lhs sorts strictly after rhs
module scs_key_cmp (
    input  logic            sort_by_column,
    input  scs_pkg::entry_t lhs,
    input  scs_pkg::entry_t rhs,
    output logic            gt
);
    import scs_pkg::*;

    logic [KEY_W-1:0] lhs_key;
    logic [KEY_W-1:0] rhs_key;

    always_comb
    begin
        if (sort_by_column)
        begin
            lhs_key = {lhs.col, lhs.row};
            rhs_key = {rhs.col, rhs.row};
        end
        else
        begin
            lhs_key = {lhs.row, lhs.col};
            rhs_key = {rhs.row, rhs.col};
        end
        gt = lhs_key > rhs_key;
    end

endmodule

// ===== rtl/scs_sequencer.sv =====
// entry memory, insertion-sort sequencer and result register
module scs_sequencer (
    input  logic              clk,
    input  logic              rst_n,
    input  scs_pkg::load_t    load,
    output logic              in_ready,
    input  logic              sort_by_column,
    output scs_pkg::result_t  res,
    output logic              res_valid,
    input  logic              res_ready
);
    import scs_pkg::*;

    localparam logic [2:0] ST_IDLE       = 3'd0;
    localparam logic [2:0] ST_SORT_RD    = 3'd1;
    localparam logic [2:0] ST_SORT_LD    = 3'd2;
    localparam logic [2:0] ST_SORT_CMP   = 3'd3;
    localparam logic [2:0] ST_SORT_PUT   = 3'd4;
    localparam logic [2:0] ST_DRAIN_RD   = 3'd5;
    localparam logic [2:0] ST_DRAIN_LD   = 3'd6;
    localparam logic [2:0] ST_DRAIN_WAIT = 3'd7;

    entry_t entry_mem [MAX_ENTRIES];
    entry_t rdata_reg;

    logic [2:0]        state_reg, state_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              bad_reg, bad_next;
    logic              res_valid_reg, res_valid_next;
    logic [ADDR_W-1:0] i_reg, i_next;
    logic [ADDR_W-1:0] j_reg, j_next;
    logic [ADDR_W-1:0] k_reg, k_next;
    entry_t            cur_reg, cur_next;
    result_t           res_reg, res_next;

    logic              mem_we;
    logic [ADDR_W-1:0] mem_waddr;
    entry_t            mem_wdata;
    logic [ADDR_W-1:0] rd_addr;
    logic              cmp_gt;
    logic              in_fire;
    logic              res_fire;
    logic              run_bad;
    logic              sort_done;

    scs_key_cmp u_cmp (
        .sort_by_column (sort_by_column),
        .lhs            (rdata_reg),
        .rhs            (cur_reg),
        .gt             (cmp_gt)
    );

    assign in_ready  = (state_reg == ST_IDLE);
    assign in_fire   = load.valid && in_ready;
    assign res_fire  = res_valid_reg && res_ready;
    assign res       = res_reg;
    assign res_valid = res_valid_reg;
    assign sort_done = (CNT_W'(i_reg) + CNT_W'(1)) == cnt_reg;
    assign run_bad   = bad_reg || load.bad || (cnt_reg == CNT_W'(MAX_ENTRIES));

    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        bad_next       = bad_reg;
        res_valid_next = res_valid_reg;
        i_next         = i_reg;
        j_next         = j_reg;
        k_next         = k_reg;
        cur_next       = cur_reg;
        res_next       = res_reg;
        mem_we         = 1'b0;
        mem_waddr      = j_reg;
        mem_wdata      = cur_reg;
        rd_addr        = i_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire)
                begin
                    if (cnt_reg != CNT_W'(MAX_ENTRIES))
                    begin
                        mem_we    = 1'b1;
                        mem_waddr = cnt_reg[ADDR_W-1:0];
                        mem_wdata = load.entry;
                        cnt_next  = cnt_reg + CNT_W'(1);
                    end
                    else
                    begin
                        bad_next = 1'b1;
                    end
                    if (load.bad)
                    begin
                        bad_next = 1'b1;
                    end
                    if (load.last)
                    begin
                        if (run_bad)
                        begin
                            res_next.entry = '0;
                            res_next.last  = 1'b1;
                            res_next.error = 1'b1;
                            res_valid_next = 1'b1;
                            state_next     = ST_DRAIN_WAIT;
                        end
                        else if (cnt_next >= CNT_W'(2))
                        begin
                            i_next     = ADDR_W'(1);
                            state_next = ST_SORT_RD;
                        end
                        else
                        begin
                            state_next = ST_DRAIN_RD;
                        end
                    end
                end
            end
            ST_SORT_RD:
            begin
                rd_addr    = i_reg;
                state_next = ST_SORT_LD;
            end
            ST_SORT_LD:
            begin
                cur_next   = rdata_reg;
                j_next     = i_reg;
                rd_addr    = i_reg - ADDR_W'(1);
                state_next = ST_SORT_CMP;
            end
            ST_SORT_CMP:
            begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                if (cmp_gt)
                begin
                    // shift the larger entry up one place
                    mem_wdata = rdata_reg;
                    j_next    = j_reg - ADDR_W'(1);
                    rd_addr   = j_reg - ADDR_W'(2);
                    if (j_reg == ADDR_W'(1))
                    begin
                        state_next = ST_SORT_PUT;
                    end
                end
                else
                begin
                    mem_wdata = cur_reg;
                    rd_addr   = i_reg + ADDR_W'(1);
                    i_next    = i_reg + ADDR_W'(1);
                    state_next = sort_done ? ST_DRAIN_RD : ST_SORT_LD;
                end
            end
            ST_SORT_PUT:
            begin
                mem_we     = 1'b1;
                mem_waddr  = '0;
                mem_wdata  = cur_reg;
                rd_addr    = i_reg + ADDR_W'(1);
                i_next     = i_reg + ADDR_W'(1);
                state_next = sort_done ? ST_DRAIN_RD : ST_SORT_LD;
            end
            ST_DRAIN_RD:
            begin
                rd_addr    = '0;
                k_next     = '0;
                state_next = ST_DRAIN_LD;
            end
            ST_DRAIN_LD:
            begin
                res_next.entry = rdata_reg;
                res_next.last  = (CNT_W'(k_reg) + CNT_W'(1)) == cnt_reg;
                res_next.error = 1'b0;
                res_valid_next = 1'b1;
                rd_addr        = k_reg + ADDR_W'(1);
                state_next     = ST_DRAIN_WAIT;
            end
            ST_DRAIN_WAIT:
            begin
                rd_addr = k_reg + ADDR_W'(1);
                if (res_fire)
                begin
                    if (res_reg.last)
                    begin
                        res_valid_next = 1'b0;
                        cnt_next       = '0;
                        bad_next       = 1'b0;
                        state_next     = ST_IDLE;
                    end
                    else
                    begin
                        // prefetched entry goes straight into the result register
                        res_next.entry = rdata_reg;
                        res_next.last  = (CNT_W'(k_reg) + CNT_W'(2)) == cnt_reg;
                        res_next.error = 1'b0;
                        k_next         = k_reg + ADDR_W'(1);
                        rd_addr        = k_reg + ADDR_W'(2);
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            bad_reg       <= 1'b0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            bad_reg       <= bad_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        i_reg   <= i_next;
        j_reg   <= j_next;
        k_reg   <= k_next;
        cur_reg <= cur_next;
        res_reg <= res_next;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            entry_mem[mem_waddr] <= mem_wdata;
        end
        rdata_reg <= entry_mem[rd_addr];
    end

endmodule

// ===== rtl/sparse_coordinate_sorter_core.sv =====
// top level of the sparse coordinate sorter
// Loads one (row, column, value) entry per cycle into a 64-entry memory until
// an entry marked last; the block then sorts the run in place by row and column
// (or column and row) with a stable insertion sort that uses one key comparator
// and one memory read port, and streams the sorted entries out. The sort opens
// with a read state; each entry is then loaded, moved down past larger keys
// and written into its slot; the drain reads ahead, then gives one result per
// cycle while the sink is ready. A run with an out-of-range index or more than
// 64 entries gives a single error result instead. Input ready is low from the
// last entry's transfer until the final result's transfer.
module sparse_coordinate_sorter_core (
    input  logic                              clk,
    input  logic                              rst_n,
    scs_in_if.sink                            in_ch,
    scs_out_if.source                         out_ch,
    input  logic                              cfg_we,
    input  logic [scs_pkg::CFG_IDX_W-1:0]     cfg_index,
    input  logic [scs_pkg::CFG_W-1:0]         cfg_wdata
);
    import scs_pkg::*;

    logic             sort_by_column_reg;
    logic [DIM_W-1:0] num_rows_reg;
    logic [DIM_W-1:0] num_cols_reg;
    load_t            load;
    result_t          res;
    logic             res_valid;
    logic             in_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sort_by_column_reg <= 1'b0;
            num_rows_reg       <= DIM_RESET;
            num_cols_reg       <= DIM_RESET;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_SORT_BY_COLUMN: sort_by_column_reg <= cfg_wdata[0];
                REG_NUM_ROWS:       num_rows_reg       <= cfg_wdata[DIM_W-1:0];
                REG_NUM_COLS:       num_cols_reg       <= cfg_wdata[DIM_W-1:0];
                default:            ;
            endcase
        end
    end

    // range check of the incoming coordinates
    always_comb
    begin
        load.valid       = in_ch.valid;
        load.last        = in_ch.last_in;
        load.entry.row   = in_ch.row_index;
        load.entry.col   = in_ch.col_index;
        load.entry.value = in_ch.entry_value;
        load.bad         = ({1'b0, in_ch.row_index} >= num_rows_reg) ||
                           ({1'b0, in_ch.col_index} >= num_cols_reg);
    end

    scs_sequencer u_seq (
        .clk            (clk),
        .rst_n          (rst_n),
        .load           (load),
        .in_ready       (in_ready),
        .sort_by_column (sort_by_column_reg),
        .res            (res),
        .res_valid      (res_valid),
        .res_ready      (out_ch.ready)
    );

    assign in_ch.ready      = in_ready;
    assign out_ch.valid     = res_valid;
    assign out_ch.out_row   = res.entry.row;
    assign out_ch.out_col   = res.entry.col;
    assign out_ch.out_value = res.entry.value;
    assign out_ch.out_last  = res.last;
    assign out_ch.out_error = res.error;

    // loading and delivering never overlap
    assert property (@(posedge clk) disable iff (!rst_n)
        !(in_ch.ready && out_ch.valid))
        else $error("input ready while a result is pending");

    // an error result always closes the run
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.out_error) |-> out_ch.out_last)
        else $error("error result without last");

    // the block takes input again right after the final transfer
    assert property (@(posedge clk) disable iff (!rst_n)
        (out_ch.valid && out_ch.ready && out_ch.out_last) |=> in_ch.ready)
        else $error("not ready after final result transfer");

    // the last input entry ends loading
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_ch.valid && in_ch.ready && in_ch.last_in) |=> !in_ch.ready)
        else $error("still loading after last entry");

endmodule

// ===== sim/tb_top.sv =====
// self-checking testbench for sparse_coordinate_sorter_core: directed table, random runs, scoreboard
module tb_top;
    import scs_pkg::*;

    localparam int WATCHDOG_LIMIT = 20000;
    localparam int SETTLE_CYCLES  = 8;
    localparam int END_CYCLES     = 32;
    localparam int RX_HOLD_CYCLES = 300;
    localparam int PHASE_ITEMS    = 20;
    localparam int NUM_PHASES     = 7;

    localparam result_t RUN_ERROR = result_t'({1'b1, 1'b1, 64'h0});

    typedef enum logic {STEP_ENTRY, STEP_REG} step_kind_t;

    typedef struct {
        step_kind_t        kind;
        logic [IDX_W-1:0]  row;
        logic [IDX_W-1:0]  col;
        logic [VAL_W-1:0]  value;
        logic              last;
        logic [CFG_IDX_W-1:0] reg_idx;
        logic [CFG_W-1:0]  reg_data;
        bit                typed;
        result_t           want;
    } step_t;

    logic                 clk = 1'b0;
    logic                 rst_n;
    logic                 cfg_we;
    logic [CFG_IDX_W-1:0] cfg_index;
    logic [CFG_W-1:0]     cfg_wdata;

    scs_in_if  in_ch ();
    scs_out_if out_ch ();

    sparse_coordinate_sorter_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_ch     (in_ch),
        .out_ch    (out_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // mirror of the block's settings and run buffer
    logic             cfg_by_col = 1'b0;
    logic [DIM_W-1:0] cfg_rows   = DIM_RESET;
    logic [DIM_W-1:0] cfg_cols   = DIM_RESET;
    entry_t           run_entries[$];
    logic             run_bad = 1'b0;
    result_t          run_out[$];
    result_t          pending_results[$];

    step_t            plan[$];
    bit               typed_on;
    result_t          typed_want;
    bit               quiet;
    bit               hold_req;
    int               fails;
    int               items_sent;
    int               stall_cycles;

    logic             phase_sort [NUM_PHASES] = '{1'b1, 1'b0, 1'b1, 1'b0, 1'b1, 1'b0, 1'b0};
    logic [DIM_W-1:0] phase_rows [NUM_PHASES] =
        '{17'h1ffff, 17'd16, 17'd5, 17'd65535, 17'd1, 17'd0, 17'h10000};
    logic [DIM_W-1:0] phase_cols [NUM_PHASES] =
        '{17'h1ffff, 17'd16, 17'd300, 17'd3, 17'h10000, 17'd7, 17'h10000};

    function automatic logic [KEY_W-1:0] order_key(input entry_t e);
        return cfg_by_col ? {e.col, e.row} : {e.row, e.col};
    endfunction

    // collect the run; on its last entry, a stable insertion sort or a single error result goes to run_out
    function automatic void absorb_entry(input entry_t e, input logic last);
        entry_t  held[$];
        entry_t  cur;
        result_t r;
        int      j;
        if ({1'b0, e.row} >= cfg_rows || {1'b0, e.col} >= cfg_cols)
            run_bad = 1'b1;
        if (run_entries.size() < MAX_ENTRIES)
            run_entries.insert(run_entries.size(), e);
        else
            run_bad = 1'b1;
        if (!last)
            return;
        if (run_bad)
        begin
            run_out.insert(run_out.size(), RUN_ERROR);
        end
        else
        begin
            held = run_entries;
            for (int i = 1; i < held.size(); i++)
            begin
                cur = held[i];
                j = i;
                while (j > 0 && order_key(held[j - 1]) > order_key(cur))
                begin
                    held[j] = held[j - 1];
                    j--;
                end
                held[j] = cur;
            end
            for (int k = 0; k < held.size(); k++)
            begin
                r.last  = (k == held.size() - 1);
                r.error = 1'b0;
                r.entry = held[k];
                run_out.insert(run_out.size(), r);
            end
        end
        run_entries.delete();
        run_bad = 1'b0;
    endfunction

    function automatic logic [IDX_W-1:0] pick_coord(input logic [DIM_W-1:0] span,
                                                     input bit out_of_range);
        int unsigned top;
        top = (span > 17'h10000) ? 32'h10000 : 32'(span);
        if (out_of_range && top < 32'h10000)
            return IDX_W'($urandom_range(65535, top));
        if (top == 0 || out_of_range)
            return IDX_W'($urandom);
        case ($urandom_range(3, 0))
            0: return IDX_W'($urandom_range((top < 4) ? top - 1 : 3, 0));
            1: return IDX_W'(top - 1);
            default: return IDX_W'($urandom_range(top - 1, 0));
        endcase
    endfunction

    // scoreboard: check results, mirror register writes, predict on each input transfer
    always @(posedge clk)
    begin
        result_t got;
        result_t want;
        entry_t  e;
        if (rst_n)
        begin
            if (out_ch.valid && out_ch.ready)
            begin
                got.last        = out_ch.out_last;
                got.error       = out_ch.out_error;
                got.entry.row   = out_ch.out_row;
                got.entry.col   = out_ch.out_col;
                got.entry.value = out_ch.out_value;
                if (pending_results.size() == 0)
                begin
                    fails++;
                    $display("%0t: unexpected result row %h col %h value %h last %b error %b",
                             $time, got.entry.row, got.entry.col, got.entry.value,
                             got.last, got.error);
                end
                else
                begin
                    want = pending_results.pop_front();
                    if (got !== want)
                    begin
                        fails++;
                        $display({"%0t: expected row %h col %h value %h last %b error %b,",
                                  " actual row %h col %h value %h last %b error %b"},
                                 $time, want.entry.row, want.entry.col, want.entry.value,
                                 want.last, want.error, got.entry.row, got.entry.col,
                                 got.entry.value, got.last, got.error);
                    end
                end
            end
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_SORT_BY_COLUMN: cfg_by_col = cfg_wdata[0];
                    REG_NUM_ROWS:       cfg_rows   = cfg_wdata[DIM_W-1:0];
                    REG_NUM_COLS:       cfg_cols   = cfg_wdata[DIM_W-1:0];
                    default: ;
                endcase
            end
            if (in_ch.valid && in_ch.ready)
            begin
                e.row   = in_ch.row_index;
                e.col   = in_ch.col_index;
                e.value = in_ch.entry_value;
                absorb_entry(e, in_ch.last_in);
                if (in_ch.last_in)
                begin
                    if (typed_on)
                        pending_results.insert(pending_results.size(), typed_want);
                    else
                        foreach (run_out[k])
                            pending_results.insert(pending_results.size(), run_out[k]);
                    run_out.delete();
                end
            end
        end
    end

    // watchdog on cycles without any transfer
    initial
    begin
        stall_cycles = 0;
        while (stall_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) || cfg_we)
                stall_cycles = 0;
            else
                stall_cycles++;
        end
        $display("sparse_coordinate_sorter_core: mismatch");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int   n;
        logic lvl;
        bit   hold_done;
        out_ch.ready = 1'b0;
        hold_done = 1'b0;
        @(posedge rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_req && !hold_done)
            begin
                lvl = 1'b0;
                n = RX_HOLD_CYCLES;
                hold_done = 1'b1;
            end
            else if (quiet)
            begin
                lvl = 1'b1;
                n = 1;
            end
            else if ($urandom_range(3, 0) == 0)
            begin
                lvl = 1'b0;
                n = $urandom_range(11, 1);
            end
            else
            begin
                lvl = 1'b1;
                n = $urandom_range(24, 1);
            end
            out_ch.ready <= lvl;
            repeat (n - 1) @(negedge clk);
        end
    end

    task automatic add_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                             input logic [VAL_W-1:0] value, input logic last);
        step_t s;
        s = '{kind: STEP_ENTRY, default: '0};
        s.kind = STEP_ENTRY;
        s.row = row;
        s.col = col;
        s.value = value;
        s.last = last;
        plan.insert(plan.size(), s);
    endtask

    task automatic add_checked(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                               input logic [VAL_W-1:0] value, input result_t want);
        step_t s;
        s = '{kind: STEP_ENTRY, default: '0};
        s.kind = STEP_ENTRY;
        s.row = row;
        s.col = col;
        s.value = value;
        s.last = 1'b1;
        s.typed = 1'b1;
        s.want = want;
        plan.insert(plan.size(), s);
    endtask

    task automatic add_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        step_t s;
        s = '{kind: STEP_REG, default: '0};
        s.kind = STEP_REG;
        s.reg_idx = idx;
        s.reg_data = data;
        plan.insert(plan.size(), s);
    endtask

    task automatic hold_sender(input int n);
        in_ch.valid <= 1'b0;
        repeat (n) @(negedge clk);
    endtask

    task automatic push_entry(input logic [IDX_W-1:0] row, input logic [IDX_W-1:0] col,
                              input logic [VAL_W-1:0] value, input logic last,
                              input bit typed, input result_t want);
        in_ch.valid       <= 1'b1;
        in_ch.row_index   <= row;
        in_ch.col_index   <= col;
        in_ch.entry_value <= value;
        in_ch.last_in     <= last;
        typed_on   = typed;
        typed_want = want;
        do
            @(posedge clk);
        while (!in_ch.ready);
        items_sent++;
        @(negedge clk);
    endtask

    task automatic wait_drained();
        in_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] data);
        wait_drained();
        cfg_index <= idx;
        cfg_wdata <= data;
        cfg_we    <= 1'b1;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    task automatic send_run(input int len, input bit with_bad, input bit calm);
        int               bad_at;
        bit               bad_row;
        logic [IDX_W-1:0] r;
        logic [IDX_W-1:0] c;
        bad_at  = with_bad ? int'($urandom_range(len - 1, 0)) : -1;
        bad_row = 1'($urandom_range(1, 0));
        for (int k = 0; k < len; k++)
        begin
            r = pick_coord(cfg_rows, k == bad_at && bad_row);
            c = pick_coord(cfg_cols, k == bad_at && !bad_row);
            if (!quiet && !calm && $urandom_range(3, 0) == 0)
                hold_sender($urandom_range(11, 1));
            push_entry(r, c, $urandom, k == len - 1, 1'b0, '0);
        end
    endtask

    function automatic int pick_len();
        int r;
        r = $urandom_range(9, 0);
        if (r < 5)
            return $urandom_range(4, 1);
        if (r < 9)
            return $urandom_range(12, 5);
        return $urandom_range(30, 13);
    endfunction

    initial
    begin
        int goal;
        rst_n             = 1'b0;
        cfg_we            = 1'b0;
        cfg_index         = '0;
        cfg_wdata         = '0;
        in_ch.valid       = 1'b0;
        in_ch.row_index   = '0;
        in_ch.col_index   = '0;
        in_ch.entry_value = '0;
        in_ch.last_in     = 1'b0;
        typed_on          = 1'b0;
        typed_want        = '0;
        quiet             = 1'b0;
        hold_req          = 1'b0;
        fails             = 0;
        items_sent        = 0;

        // single-entry runs at the field extremes under reset settings
        add_checked(16'h0000, 16'h0000, 32'h00000000,
                    result_t'({1'b1, 1'b0, 16'h0000, 16'h0000, 32'h00000000}));
        add_checked(16'hffff, 16'hffff, 32'h7fffffff,
                    result_t'({1'b1, 1'b0, 16'hffff, 16'hffff, 32'h7fffffff}));
        add_checked(16'h8000, 16'h0001, 32'h80000000,
                    result_t'({1'b1, 1'b0, 16'h8000, 16'h0001, 32'h80000000}));
        // row-major run with a repeated coordinate
        add_entry(16'd5, 16'd3, 32'd1, 1'b0);
        add_entry(16'd2, 16'd9, 32'd2, 1'b0);
        add_entry(16'd5, 16'd3, 32'd3, 1'b0);
        add_entry(16'd2, 16'd1, 32'd4, 1'b0);
        add_entry(16'd0, 16'hffff, 32'hffffffff, 1'b1);
        // column-major on a 4 x 8 matrix
        add_reg(REG_SORT_BY_COLUMN, 17'd1);
        add_reg(REG_NUM_ROWS, 17'd4);
        add_reg(REG_NUM_COLS, 17'd8);
        add_entry(16'd3, 16'd7, 32'd10, 1'b0);
        add_entry(16'd0, 16'd7, 32'd11, 1'b0);
        add_entry(16'd3, 16'd0, 32'd12, 1'b0);
        add_entry(16'd3, 16'd7, 32'd13, 1'b0);
        add_entry(16'd1, 16'd2, 32'd14, 1'b1);
        // row out of range, column out of range, bad entry in the middle of a run
        add_checked(16'd4, 16'd0, 32'd5, RUN_ERROR);
        add_checked(16'd0, 16'd8, 32'd5, RUN_ERROR);
        add_entry(16'd1, 16'd1, 32'd1, 1'b0);
        add_entry(16'd0, 16'd9, 32'd2, 1'b0);
        add_checked(16'd2, 16'd2, 32'd3, RUN_ERROR);
        add_checked(16'd3, 16'd7, 32'h55aa55aa,
                    result_t'({1'b1, 1'b0, 16'd3, 16'd7, 32'h55aa55aa}));
        // 1 x 1 matrix, then zero rows
        add_reg(REG_SORT_BY_COLUMN, 17'd0);
        add_reg(REG_NUM_ROWS, 17'd1);
        add_reg(REG_NUM_COLS, 17'd1);
        add_checked(16'd0, 16'd0, 32'h12345678,
                    result_t'({1'b1, 1'b0, 16'd0, 16'd0, 32'h12345678}));
        add_checked(16'd1, 16'd0, 32'h12345678, RUN_ERROR);
        add_reg(REG_NUM_ROWS, 17'd0);
        add_checked(16'd0, 16'd0, 32'd1, RUN_ERROR);
        add_reg(REG_NUM_ROWS, 17'h1ffff);
        add_reg(REG_NUM_COLS, 17'h1ffff);
        add_checked(16'hffff, 16'h0000, 32'hdeadbeef,
                    result_t'({1'b1, 1'b0, 16'hffff, 16'h0000, 32'hdeadbeef}));

        repeat (5) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].kind == STEP_REG)
            begin
                write_reg(plan[i].reg_idx, plan[i].reg_data);
            end
            else
            begin
                if ($urandom_range(3, 0) == 0)
                    hold_sender($urandom_range(11, 1));
                push_entry(plan[i].row, plan[i].col, plan[i].value, plan[i].last,
                           plan[i].typed, plan[i].want);
            end
        end

        for (int p = 0; p < NUM_PHASES; p++)
        begin
            write_reg(REG_SORT_BY_COLUMN, CFG_W'(phase_sort[p]));
            write_reg(REG_NUM_ROWS, phase_rows[p]);
            write_reg(REG_NUM_COLS, phase_cols[p]);
            quiet = (p == NUM_PHASES - 1);
            if (p == 0)
            begin
                // sink holds off while runs keep coming so the input stalls
                hold_req = 1'b1;
                send_run(6, 1'b0, 1'b1);
                send_run(4, 1'b0, 1'b1);
            end
            if (p == 1)
                send_run(MAX_ENTRIES, 1'b0, 1'b0);
            if (p == 2)
                send_run(MAX_ENTRIES + 1 + $urandom_range(3, 0), 1'b0, 1'b0);
            goal = items_sent + PHASE_ITEMS;
            while (items_sent < goal)
                send_run(pick_len(), $urandom_range(7, 0) == 0, $urandom_range(4, 0) == 0);
        end

        wait_drained();
        repeat (END_CYCLES) @(negedge clk);
        if (fails == 0 && pending_results.size() == 0)
            $display("sparse_coordinate_sorter_core: match");
        else
            $display("sparse_coordinate_sorter_core: mismatch");
        $finish;
    end

endmodule
